// File: rtl/core/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg
// shared types and constants of the websocket frame parser
// ----------------------------------------------------------------------------
package wsfp_pkg;

	localparam int LENGTH_BITS = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [31:0] MAX_LEN_RESET = 32'd67108864;

	// frame opcodes
	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_TEXT = 4'h1;
	localparam logic [3:0] OP_BIN  = 4'h2;
	localparam logic [3:0] OP_PING = 4'h9;
	localparam logic [3:0] OP_PONG = 4'hA;

	// payload actions (drop, else kind plus one)
	localparam logic [2:0] ACT_DROP  = 3'd0;
	localparam logic [2:0] ACT_TEXT  = 3'd1;
	localparam logic [2:0] ACT_BIN   = 3'd2;
	localparam logic [2:0] ACT_PING  = 3'd3;
	localparam logic [2:0] ACT_CLOSE = 3'd4;

	localparam logic [2:0] KIND_OVERSIZE = 3'd4;

	// header lengths
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [2:0] HCNT_EXT16 = 3'd2;
	localparam logic [2:0] HCNT_EXT64 = 3'd0;
	localparam logic [2:0] HCNT_KEY   = 3'd4;

	// register map (word index)
	localparam logic REG_MAX_LEN = 1'b0;
	localparam logic REG_REASM   = 1'b1;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_MASK,
		PH_PAYLOAD,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       frame_end;
		logic       message_end;
		logic       fragment_stream;
		logic       restart;
	} result_t;

	typedef struct packed {
		logic [31:0] max_frame_length;
		logic        reassembly_enabled;
	} cfg_t;

endpackage

// File: rtl/core/wsfp_front.sv
// ----------------------------------------------------------------------------
// wsfp_front
// byte-serial header parser and payload unmasking, one byte per cycle while in_valid is high
// ----------------------------------------------------------------------------
module wsfp_front import wsfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	output logic       res_valid,
	output result_t    res
);

	phase_t                  phase_q, phase_n;
	logic                    fin_q, masked_q;
	logic [3:0]              opcode_q;
	logic [LENGTH_BITS-1:0]  len_q, len_n;
	logic [2:0]              hcnt_q, hcnt_n;
	logic [31:0]             key_q, key_n;
	logic [1:0]              midx_q, midx_n;
	logic                    in_frag_q, in_frag_n;
	logic                    frag_bin_q, frag_bin_n;
	logic [2:0]              action_q, action_n;
	logic                    restart_q, restart_n;

	// decode signals
	logic [6:0]              len7;
	logic [2:0]              hcnt_dec;
	logic [LENGTH_BITS-1:0]  ext_len, len_fin, len_dec;
	logic                    finish, oversize, len_zero, last;
	logic [2:0]              action_fin;
	logic                    start_frag;
	logic [7:0]              key_byte, unmasked;

	always_comb begin
		len7     = in_byte[6:0];
		hcnt_dec = hcnt_q - 3'd1;
		if (len_q[LENGTH_BITS-1 -: 8] != 8'd0) begin
			ext_len = '1;
		end else begin
			ext_len = {len_q[LENGTH_BITS-9:0], in_byte};
		end
		len_dec = len_q - LENGTH_BITS'(1);
		last    = (len_dec == '0);

		finish  = 1'b0;
		len_fin = len_q;
		unique case (phase_q)
			PH_HDR1: begin
				finish  = (len7 != LEN7_EXT16) && (len7 != LEN7_EXT64) && !in_byte[7];
				len_fin = LENGTH_BITS'(len7);
			end
			PH_EXTLEN: begin
				finish  = (hcnt_dec == 3'd0) && !masked_q;
				len_fin = ext_len;
			end
			PH_MASK: finish = (hcnt_dec == 3'd0);
			default: finish = 1'b0;
		endcase
		finish   = finish && in_valid;
		oversize = (len_fin > LENGTH_BITS'(cfg.max_frame_length)) || (len_fin == '1);
		len_zero = (len_fin == '0);

		start_frag = 1'b0;
		case (opcode_q) inside
			OP_PING: action_fin = ACT_PING;
			OP_PONG: action_fin = ACT_DROP;
			OP_CONT: begin
				if (cfg.reassembly_enabled && in_frag_q) begin
					action_fin = frag_bin_q ? ACT_BIN : ACT_TEXT;
				end else begin
					action_fin = ACT_DROP;
				end
			end
			OP_TEXT, OP_BIN: begin
				action_fin = opcode_q[2:0];
				if (!fin_q) begin
					if (cfg.reassembly_enabled) begin
						start_frag = 1'b1;
					end else begin
						action_fin = ACT_DROP;
					end
				end
			end
			default: action_fin = ACT_CLOSE;
		endcase

		case (midx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		unmasked = masked_q ? (in_byte ^ key_byte) : in_byte;
	end

	// next phase
	always_comb begin
		phase_n = phase_q;
		if (in_valid) begin
			unique case (phase_q)
				PH_HDR0: phase_n = PH_HDR1;
				PH_HDR1: begin
					if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
						phase_n = PH_EXTLEN;
					end else if (in_byte[7]) begin
						phase_n = PH_MASK;
					end
				end
				PH_EXTLEN: begin
					if (hcnt_dec == 3'd0 && masked_q) begin
						phase_n = PH_MASK;
					end
				end
				PH_PAYLOAD: if (last) phase_n = PH_HDR0;
				PH_SKIP:    if (last) phase_n = PH_HDR0;
				default:    phase_n = phase_q;
			endcase
			if (finish) begin
				if (oversize) begin
					phase_n = len_zero ? PH_HDR0 : PH_SKIP;
				end else begin
					phase_n = len_zero ? PH_HDR0 : PH_PAYLOAD;
				end
			end
		end
	end

	// datapath state and result
	always_comb begin
		len_n      = len_q;
		hcnt_n     = hcnt_q;
		key_n      = key_q;
		midx_n     = midx_q;
		in_frag_n  = in_frag_q;
		frag_bin_n = frag_bin_q;
		action_n   = action_q;
		restart_n  = restart_q;
		res_valid  = 1'b0;
		res        = '0;
		if (in_valid) begin
			case (phase_q)
				PH_HDR1: begin
					key_n = '0;
					if (len7 == LEN7_EXT16) begin
						len_n  = '0;
						hcnt_n = HCNT_EXT16;
					end else if (len7 == LEN7_EXT64) begin
						len_n  = '0;
						hcnt_n = HCNT_EXT64;
					end else begin
						len_n = len_fin;
						if (in_byte[7]) hcnt_n = HCNT_KEY;
					end
				end
				PH_EXTLEN: begin
					len_n  = ext_len;
					hcnt_n = (hcnt_dec == 3'd0 && masked_q) ? HCNT_KEY : hcnt_dec;
				end
				PH_MASK: begin
					key_n  = {key_q[23:0], in_byte};
					hcnt_n = hcnt_dec;
				end
				PH_PAYLOAD: begin
					len_n  = len_dec;
					midx_n = midx_q + 2'd1;
					if (action_q != ACT_DROP) begin
						res_valid           = 1'b1;
						res.kind            = action_q - 3'd1;
						res.data_byte       = unmasked;
						res.byte_valid      = 1'b1;
						res.frame_end       = last;
						res.message_end     = last && fin_q &&
						                      (action_q == ACT_TEXT || action_q == ACT_BIN);
						res.fragment_stream = (action_q == ACT_TEXT || action_q == ACT_BIN) &&
						                      (opcode_q == OP_CONT || !fin_q);
						res.restart         = restart_q;
						restart_n           = 1'b0;
						// closing continuation ends the fragmented message
						if (last && opcode_q == OP_CONT && fin_q) in_frag_n = 1'b0;
					end
				end
				PH_SKIP: len_n = len_dec;
				default: len_n = len_q;
			endcase

			if (finish) begin
				midx_n = 2'd0;
				if (oversize) begin
					// fragment state left alone, pending restart kept
					action_n       = ACT_DROP;
					res_valid      = 1'b1;
					res.kind       = KIND_OVERSIZE;
					res.frame_end  = 1'b1;
				end else begin
					action_n = action_fin;
					if (start_frag) begin
						in_frag_n  = 1'b1;
						frag_bin_n = (opcode_q == OP_BIN);
					end
					if (len_zero && action_fin != ACT_DROP) begin
						res_valid           = 1'b1;
						res.kind            = action_fin - 3'd1;
						res.frame_end       = 1'b1;
						res.message_end     = fin_q &&
						                      (action_fin == ACT_TEXT || action_fin == ACT_BIN);
						res.fragment_stream = (action_fin == ACT_TEXT || action_fin == ACT_BIN) &&
						                      (opcode_q == OP_CONT || !fin_q);
						res.restart         = restart_q || (start_frag && in_frag_q);
						restart_n           = 1'b0;
						if (opcode_q == OP_CONT && fin_q) in_frag_n = 1'b0;
					end else if (start_frag && in_frag_q) begin
						restart_n = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			fin_q      <= 1'b0;
			opcode_q   <= '0;
			masked_q   <= 1'b0;
			len_q      <= '0;
			hcnt_q     <= '0;
			key_q      <= '0;
			midx_q     <= '0;
			in_frag_q  <= 1'b0;
			frag_bin_q <= 1'b0;
			action_q   <= ACT_DROP;
			restart_q  <= 1'b0;
		end else begin
			phase_q    <= phase_n;
			len_q      <= len_n;
			hcnt_q     <= hcnt_n;
			key_q      <= key_n;
			midx_q     <= midx_n;
			in_frag_q  <= in_frag_n;
			frag_bin_q <= frag_bin_n;
			action_q   <= action_n;
			restart_q  <= restart_n;
			if (in_valid && phase_q == PH_HDR0) begin
				fin_q    <= in_byte[7];
				opcode_q <= in_byte[3:0];
			end
			if (in_valid && phase_q == PH_HDR1) begin
				masked_q <= in_byte[7];
			end
		end
	end

endmodule

// File: rtl/core/wsfp_queue.sv
// ----------------------------------------------------------------------------
// wsfp_queue
// short result queue between parser and consumer
// ----------------------------------------------------------------------------
module wsfp_queue import wsfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_data,
	input  logic    rd_en,
	output result_t rd_data,
	output logic    full,
	output logic    empty
);

	result_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_wr, do_rd;

	assign full    = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/websocket_frame_parser.sv
// ----------------------------------------------------------------------------
// websocket_frame_parser
// receive-side frame parser: header walk, payload unmask, tagged result items
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  input     | push / full        | in_byte
//  result    | pop / empty        | kind, data_byte, byte_valid, frame_end,
//            |                    | message_end, fragment_stream, restart
//  config    | apb psel/penable   | paddr, pwdata, prdata (reg 0 at 0, 1 at 4)
//
//  one byte is taken per cycle while full is low; its result, if any, is in
//  the queue in the next cycle and shows on the result ports while empty is low
//  the parser keeps running while results wait: full rises only when the
//  four-entry result queue has no room, the only thing that stalls input
//  reset brings the parser to the first header byte and the registers to
//  their defaults (max length 64 MiB, reassembly on)
// ----------------------------------------------------------------------------
module websocket_frame_parser import wsfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	// results out
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  kind,
	output logic [7:0]  data_byte,
	output logic        byte_valid,
	output logic        frame_end,
	output logic        message_end,
	output logic        fragment_stream,
	output logic        restart,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t    cfg_q;
	logic    accept;
	logic    res_valid;
	result_t res, head;
	logic    cfg_wr;

	// config registers; word index taken from paddr bit 2
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_frame_length   <= MAX_LEN_RESET;
			cfg_q.reassembly_enabled <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MAX_LEN) begin
				cfg_q.max_frame_length <= pwdata;
			end else begin
				cfg_q.reassembly_enabled <= pwdata[0];
			end
		end
	end

	// read-back mux
	always_comb begin
		unique case (paddr[2])
			REG_MAX_LEN: prdata = cfg_q.max_frame_length;
			REG_REASM:   prdata = {31'd0, cfg_q.reassembly_enabled};
			default:     prdata = '0;
		endcase
	end

	// input is taken whenever the result queue has a free slot
	assign accept = push && !full;

	// front: header parse and unmask
	wsfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (accept),
		.in_byte   (in_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	// back: result queue toward the consumer
	wsfp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.rd_en   (pop),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	// oldest waiting result on the ports
	assign kind            = head.kind;
	assign data_byte       = head.data_byte;
	assign byte_valid      = head.byte_valid;
	assign frame_end       = head.frame_end;
	assign message_end     = head.message_end;
	assign fragment_stream = head.fragment_stream;
	assign restart         = head.restart;

endmodule

// File: tb/websocket_frame_parser_test.sv
// ----------------------------------------------------------------------------
// websocket_frame_parser_test
// self-checking bench: byte stream in, tagged result items out, apb config
// ----------------------------------------------------------------------------
// a short directed table of frames covers every opcode, the three length
// forms, masking, zero-length markers, oversize skip and fragment restart;
// then random well-formed messages with noise frames are sent under several
// register settings, both sides idling at random in the first four. every accepted byte runs
// through a local predictor and every popped result is compared field by field
// ----------------------------------------------------------------------------
module websocket_frame_parser_test;
	import wsfp_pkg::*;

	localparam int          CLK_HALF       = 6;
	localparam int          TIMEOUT_CYCLES = 400000;
	localparam int          PHASE_BYTES    = 180;
	localparam logic [3:0]  OP_CLOSE       = 4'h8;
	localparam logic [2:0]  KIND_TEXT      = 3'd0;
	localparam logic [2:0]  KIND_BIN       = 3'd1;
	localparam logic [2:0]  KIND_PING      = 3'd2;
	localparam logic [2:0]  KIND_CLOSE     = 3'd3;

	typedef enum logic [1:0] {
		LEN_SHORT,
		LEN_EXT16,
		LEN_EXT64
	} len_form_t;

	// one directed frame; marker is typed in only where it is obvious
	typedef struct packed {
		logic [7:0]  head;
		logic        masked;
		len_form_t   form;
		logic [15:0] length;
		logic [31:0] key;
		logic        typed;
		result_t     marker;
	} frame_row_t;

	localparam result_t NO_MARKER = '0;

	// runs with max_frame_length 2 and reassembly on
	localparam frame_row_t DIRECTED_FRAMES [14] = '{
		// empty final text
		'{8'h81, 1'b0, LEN_SHORT, 16'd0, 32'h0, 1'b1,
			'{KIND_TEXT, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
		// masked binary with an all-ones key
		'{8'h82, 1'b1, LEN_SHORT, 16'd2, 32'hFFFF_FFFF, 1'b0, NO_MARKER},
		// empty ping
		'{8'h89, 1'b0, LEN_SHORT, 16'd0, 32'h0, 1'b1,
			'{KIND_PING, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
		// pong is swallowed
		'{8'h8A, 1'b0, LEN_SHORT, 16'd1, 32'h0, 1'b0, NO_MARKER},
		// empty close
		'{8'h88, 1'b0, LEN_SHORT, 16'd0, 32'h0, 1'b1,
			'{KIND_CLOSE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
		// reserved opcode with all reserved header bits set
		'{8'hF3, 1'b0, LEN_SHORT, 16'd0, 32'h0, 1'b1,
			'{KIND_CLOSE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
		// continuation with nothing open is swallowed
		'{8'h80, 1'b0, LEN_SHORT, 16'd1, 32'h0, 1'b0, NO_MARKER},
		// text fragment opens a message
		'{8'h01, 1'b1, LEN_SHORT, 16'd1, 32'h1234_5678, 1'b0, NO_MARKER},
		// binary fragment while text is open: restart marker
		'{8'h02, 1'b0, LEN_SHORT, 16'd0, 32'h0, 1'b1,
			'{KIND_BIN, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
		// complete text inside the open message
		'{8'h81, 1'b0, LEN_SHORT, 16'd1, 32'h0, 1'b0, NO_MARKER},
		// final continuation in 16-bit length form
		'{8'h80, 1'b0, LEN_EXT16, 16'd2, 32'h0, 1'b0, NO_MARKER},
		// over the limit: oversize marker, payload skipped
		'{8'h81, 1'b0, LEN_SHORT, 16'd3, 32'h0, 1'b1,
			'{KIND_OVERSIZE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
		// empty binary in 64-bit length form with a mask key
		'{8'h82, 1'b1, LEN_EXT64, 16'd0, 32'h0, 1'b1,
			'{KIND_BIN, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
		// non-final reserved opcode
		'{8'h7F, 1'b0, LEN_SHORT, 16'd0, 32'h0, 1'b1,
			'{KIND_CLOSE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}}
	};

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        push    = 1'b0;
	logic        full;
	logic [7:0]  in_byte = 8'h00;
	logic        pop     = 1'b0;
	logic        empty;
	logic [2:0]  kind;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        frame_end;
	logic        message_end;
	logic        fragment_stream;
	logic        restart;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = 3'd0;
	logic [31:0] pwdata  = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	websocket_frame_parser dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.in_byte         (in_byte),
		.pop             (pop),
		.empty           (empty),
		.kind            (kind),
		.data_byte       (data_byte),
		.byte_valid      (byte_valid),
		.frame_end       (frame_end),
		.message_end     (message_end),
		.fragment_stream (fragment_stream),
		.restart         (restart),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// predictor state, a shadow of the parser
	logic [31:0] cfg_max_len   = MAX_LEN_RESET;
	logic        cfg_reasm     = 1'b1;
	phase_t      p_phase       = PH_HDR0;
	logic        f_fin         = 1'b0;
	logic [3:0]  f_op          = 4'h0;
	logic        f_masked      = 1'b0;
	logic [63:0] f_len         = 64'd0;
	logic [2:0]  hdr_left      = 3'd0;
	logic [31:0] f_key         = 32'h0;
	logic [1:0]  key_idx       = 2'd0;
	logic        frag_open     = 1'b0;
	logic        frag_bin      = 1'b0;
	logic        restart_due   = 1'b0;
	logic [2:0]  p_action      = ACT_DROP;

	result_t     expected_results [$];
	result_t     typed_markers [$];
	result_t     oldest;
	int          mismatches    = 0;
	int          bytes_sent    = 0;
	int          send_idle_pct = 20;
	int          recv_idle_pct = 56;

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// flags of a result item of the current frame; consumes a pending restart
	function automatic result_t frame_result(input logic [2:0] k, input logic [7:0] d,
			input logic v, input logic fe);
		result_t r;
		logic    data_frame;
		data_frame        = (p_action == ACT_TEXT) || (p_action == ACT_BIN);
		r.kind            = k;
		r.data_byte       = d;
		r.byte_valid      = v;
		r.frame_end       = fe;
		r.message_end     = fe && data_frame && f_fin;
		r.fragment_stream = data_frame && ((f_op == OP_CONT) || !f_fin);
		r.restart         = restart_due;
		restart_due       = 1'b0;
		return r;
	endfunction

	// a typed directed marker, where one waits, stands in for the prediction
	task automatic queue_expected(input result_t r);
		if (!r.byte_valid && typed_markers.size() != 0) begin
			r = typed_markers.pop_front();
		end
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic close_frame();
		if (f_op == OP_CONT && f_fin && p_action != ACT_DROP) begin
			frag_open = 1'b0;
		end
		p_phase = PH_HDR0;
	endtask

	task automatic finish_header();
		result_t r;
		key_idx = 2'd0;
		if (f_len > {32'd0, cfg_max_len} || f_len == '1) begin
			// oversize: one marker, fragment state left alone
			p_action    = ACT_DROP;
			r           = '0;
			r.kind      = KIND_OVERSIZE;
			r.frame_end = 1'b1;
			queue_expected(r);
			p_phase = (f_len != 0) ? PH_SKIP : PH_HDR0;
		end else begin
			case (f_op) inside
				OP_PING: p_action = ACT_PING;
				OP_PONG: p_action = ACT_DROP;
				OP_CONT: begin
					if (cfg_reasm && frag_open) begin
						p_action = frag_bin ? ACT_BIN : ACT_TEXT;
					end else begin
						p_action = ACT_DROP;
					end
				end
				OP_TEXT, OP_BIN: begin
					p_action = (f_op == OP_BIN) ? ACT_BIN : ACT_TEXT;
					if (!f_fin) begin
						if (cfg_reasm) begin
							if (frag_open) begin
								restart_due = 1'b1;
							end
							frag_open = 1'b1;
							frag_bin  = (f_op == OP_BIN);
						end else begin
							p_action = ACT_DROP;
						end
					end
				end
				default: p_action = ACT_CLOSE;
			endcase
			if (f_len == 0) begin
				// empty frame: marker at the end of the header
				if (p_action != ACT_DROP) begin
					queue_expected(frame_result(p_action - 3'd1, 8'h00, 1'b0, 1'b1));
				end
				close_frame();
			end else begin
				p_phase = PH_PAYLOAD;
			end
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic [7:0] d;
		case (p_phase)
			PH_HDR0: begin
				f_fin   = b[7];
				f_op    = b[3:0];
				p_phase = PH_HDR1;
			end
			PH_HDR1: begin
				f_masked = b[7];
				f_len    = 64'd0;
				f_key    = 32'h0;
				if (b[6:0] == LEN7_EXT16) begin
					hdr_left = HCNT_EXT16;
					p_phase  = PH_EXTLEN;
				end else if (b[6:0] == LEN7_EXT64) begin
					// eight bytes, the count wraps through zero
					hdr_left = HCNT_EXT64;
					p_phase  = PH_EXTLEN;
				end else begin
					f_len = 64'(b[6:0]);
					if (f_masked) begin
						hdr_left = HCNT_KEY;
						p_phase  = PH_MASK;
					end else begin
						finish_header();
					end
				end
			end
			PH_EXTLEN: begin
				if (f_len[63:56] != 8'h00) begin
					f_len = '1;
				end else begin
					f_len = {f_len[55:0], b};
				end
				hdr_left = hdr_left - 3'd1;
				if (hdr_left == 3'd0) begin
					if (f_masked) begin
						hdr_left = HCNT_KEY;
						p_phase  = PH_MASK;
					end else begin
						finish_header();
					end
				end
			end
			PH_MASK: begin
				f_key    = {f_key[23:0], b};
				hdr_left = hdr_left - 3'd1;
				if (hdr_left == 3'd0) begin
					finish_header();
				end
			end
			PH_PAYLOAD: begin
				d = b;
				if (f_masked) begin
					d = b ^ f_key[8 * (3 - key_idx) +: 8];
				end
				key_idx = key_idx + 2'd1;
				f_len   = f_len - 64'd1;
				if (p_action != ACT_DROP) begin
					queue_expected(frame_result(p_action - 3'd1, d, 1'b1, f_len == 0));
				end
				if (f_len == 0) begin
					close_frame();
				end
			end
			PH_SKIP: begin
				f_len = f_len - 64'd1;
				if (f_len == 0) begin
					p_phase = PH_HDR0;
				end
			end
			default: p_phase = PH_HDR0;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// result check and prediction, both on the rising edge
	// ------------------------------------------------------------------------

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected item expected none actual kind %0h data %0h",
						$time, kind, data_byte);
					mismatches++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("kind", 8'(oldest.kind), 8'(kind));
					check_field("data_byte", oldest.data_byte, data_byte);
					check_field("byte_valid", 8'(oldest.byte_valid), 8'(byte_valid));
					check_field("frame_end", 8'(oldest.frame_end), 8'(frame_end));
					check_field("message_end", 8'(oldest.message_end), 8'(message_end));
					check_field("fragment_stream", 8'(oldest.fragment_stream),
						8'(fragment_stream));
					check_field("restart", 8'(oldest.restart), 8'(restart));
				end
			end
			// the result of this byte can be popped from the next cycle on at the earliest
			if (push && !full) begin
				parse_byte(in_byte);
			end
		end
	end

	// receiver stalls at random
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	// entered and left at a falling edge; push is assigned once per edge
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push    <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] head, input logic masked,
			input len_form_t form, input logic [63:0] length, input logic [31:0] key);
		logic [63:0] n;
		send_byte(head);
		case (form)
			LEN_SHORT: send_byte({masked, length[6:0]});
			LEN_EXT16: begin
				send_byte({masked, LEN7_EXT16});
				send_byte(length[15:8]);
				send_byte(length[7:0]);
			end
			default: begin
				send_byte({masked, LEN7_EXT64});
				for (int i = 7; i >= 0; i--) begin
					send_byte(length[8 * i +: 8]);
				end
			end
		endcase
		if (masked) begin
			for (int i = 3; i >= 0; i--) begin
				send_byte(key[8 * i +: 8]);
			end
		end
		for (n = 0; n < length; n++) begin
			send_byte(8'($urandom_range(255)));
		end
	endtask

	// random length, form, mask and reserved bits; mostly short payloads
	task automatic send_random_body(input logic fin, input logic [3:0] op);
		logic [63:0] len;
		len_form_t   form;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			len = 64'($urandom_range(12));
		end else if (pick < 95) begin
			len = 64'($urandom_range(60, 13));
		end else begin
			len = 64'($urandom_range(300, 126));
		end
		pick = $urandom_range(99);
		if (len >= 126 || pick < 12) begin
			form = LEN_EXT16;
		end else if (pick < 20) begin
			form = LEN_EXT64;
		end else begin
			form = LEN_SHORT;
		end
		send_frame({fin, 3'($urandom_range(7)), op}, 1'($urandom_range(1)), form, len,
			$urandom);
	endtask

	task automatic send_random_message();
		logic [3:0] op;
		int         parts;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			// fragmented message with control frames mixed in, now and then left open
			send_random_body(1'b0, $urandom_range(1) ? OP_BIN : OP_TEXT);
			parts = $urandom_range(3);
			repeat (parts) begin
				if ($urandom_range(3) == 0) begin
					send_random_body(1'b1, $urandom_range(1) ? OP_PING : OP_PONG);
				end
				send_random_body(1'b0, OP_CONT);
			end
			if ($urandom_range(9) != 0) begin
				send_random_body(1'b1, OP_CONT);
			end
		end else begin
			// single frames, stray continuations and raw opcodes as noise
			if (pick < 70) begin
				op = $urandom_range(1) ? OP_BIN : OP_TEXT;
			end else if (pick < 78) begin
				op = OP_PING;
			end else if (pick < 84) begin
				op = OP_PONG;
			end else if (pick < 89) begin
				op = OP_CLOSE;
			end else if (pick < 94) begin
				op = OP_CONT;
			end else begin
				op = 4'($urandom_range(15));
			end
			send_random_body($urandom_range(99) < 80, op);
		end
	endtask

	// sender holds off until every expected item is out, or until the wait gives up
	task automatic drain_results();
		int waited;
		push <= 1'b0;
		for (waited = 0; expected_results.size() != 0 && waited < 5000; waited++) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// apb write: setup, access, then a quiet phase with psel low before the next transfer
	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_MAX_LEN) begin
			cfg_max_len = value;
		end else begin
			cfg_reasm = value[0];
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [31:0] max_len;
		logic        reasm;
		int          regime;
		int          target;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames, tight limit so oversize stays cheap
		write_reg(REG_MAX_LEN, 32'd2);
		write_reg(REG_REASM, 32'd1);
		for (int i = 0; i < $size(DIRECTED_FRAMES); i++) begin
			if (DIRECTED_FRAMES[i].typed) begin
				typed_markers.insert(typed_markers.size(), DIRECTED_FRAMES[i].marker);
			end
			send_frame(DIRECTED_FRAMES[i].head, DIRECTED_FRAMES[i].masked,
				DIRECTED_FRAMES[i].form, 64'(DIRECTED_FRAMES[i].length),
				DIRECTED_FRAMES[i].key);
		end

		// random messages under six settings, two per idling regime
		for (int ph = 0; ph < 6; ph++) begin
			drain_results();
			case (ph)
				0: begin
					max_len = 32'hFFFF_FFFF;
					reasm   = 1'b1;
				end
				1: begin
					max_len = 32'd0;
					reasm   = 1'b0;
				end
				2: begin
					max_len = 32'($urandom_range(40, 8));
					reasm   = 1'b1;
				end
				3: begin
					max_len = 32'($urandom_range(12, 1));
					reasm   = 1'b0;
				end
				4: begin
					max_len = MAX_LEN_RESET;
					reasm   = 1'b1;
				end
				default: begin
					max_len = 32'($urandom_range(300));
					reasm   = 1'b1;
				end
			endcase
			write_reg(REG_MAX_LEN, max_len);
			write_reg(REG_REASM, 32'(reasm));
			regime        = ph / 2;
			send_idle_pct = (regime == 0) ? 20 : (regime == 1) ? 56 : 0;
			recv_idle_pct = (regime == 0) ? 56 : (regime == 1) ? 20 : 0;
			target        = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				send_random_message();
			end
		end

		// all-ones 64-bit length is oversize; the parser then skips for good
		typed_markers.insert(typed_markers.size(),
			result_t'{KIND_OVERSIZE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
		send_byte({1'b1, 3'b000, OP_BIN});
		send_byte({1'b0, LEN7_EXT64});
		repeat (8) send_byte(8'hFF);

		drain_results();
		repeat (8) @(negedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: items still expected %0d actual none", $time,
				expected_results.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// hard stop for a hung handshake
	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
